FILE: hw/rtl/sgacs_pkg.sv
// Package: shared types, constants and gesture codes for the stick gesture block
`timescale 1ns / 1ps
package sgacs_pkg;

  localparam int unsigned NumLanes = 6;
  localparam int unsigned ChW      = 12;
  localparam int unsigned NumRegs  = 8;
  localparam int unsigned AddrW    = 5;

  typedef enum logic [2:0] {
    G_UNKNOWN   = 3'd0,
    G_DISARM    = 3'd1,
    G_ARM       = 3'd2,
    G_CALIBRATE = 3'd3,
    G_RECORD    = 3'd4,
    G_READ      = 3'd5
  } gesture_e;

  typedef enum logic [2:0] {
    REG_STICK_LOW     = 3'd0,
    REG_STICK_HIGH    = 3'd1,
    REG_HOLD_FRAMES   = 3'd2,
    REG_THR_FLOOR     = 3'd3,
    REG_THR_CEILING   = 3'd4,
    REG_AIL_SPAN      = 3'd5,
    REG_ELE_SPAN      = 3'd6,
    REG_RUD_SPAN      = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } state_e;

  localparam logic CMD_FRAME    = 1'b0;
  localparam logic CMD_FAILSAFE = 1'b1;

  typedef struct packed {
    logic [ChW-1:0]  lo;
    logic [ChW-1:0]  hi;
  } thresh_t;

  typedef struct packed {
    logic is_armed;
    logic arm_pulse;
    logic calibrate_pulse;
    logic record_pulse;
    logic read_pulse;
  } flags_t;

  typedef struct packed {
    logic start;
    logic done;
  } lane_ctl_t;

endpackage

FILE: hw/rtl/sgacs_if.sv
// Interfaces: input request channel and result channel
`timescale 1ns / 1ps
interface sgacs_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [11:0] throttle_in;
  logic [11:0] aileron_in;
  logic [11:0] elevator_in;
  logic [11:0] rudder_in;
  logic [11:0] aux_one_in;
  logic [11:0] aux_two_in;
  modport source (output valid, command, throttle_in, aileron_in, elevator_in, rudder_in,
                  aux_one_in, aux_two_in, input ready);
  modport sink (input valid, command, throttle_in, aileron_in, elevator_in, rudder_in,
                aux_one_in, aux_two_in, output ready);
endinterface

interface sgacs_out_if;
  logic               valid;
  logic               ready;
  logic        [11:0] throttle_target;
  logic signed [11:0] aileron_target;
  logic signed [11:0] elevator_target;
  logic signed [11:0] rudder_target;
  logic signed [11:0] aux_one_target;
  logic signed [11:0] aux_two_target;
  logic               is_armed;
  logic               arm_pulse;
  logic               calibrate_pulse;
  logic               record_pulse;
  logic               read_pulse;
  logic        [15:0] frame_count;
  modport source (output valid, throttle_target, aileron_target, elevator_target,
                  rudder_target, aux_one_target, aux_two_target, is_armed, arm_pulse,
                  calibrate_pulse, record_pulse, read_pulse, frame_count, input ready);
  modport sink (input valid, throttle_target, aileron_target, elevator_target,
                rudder_target, aux_one_target, aux_two_target, is_armed, arm_pulse,
                calibrate_pulse, record_pulse, read_pulse, frame_count, output ready);
endinterface

FILE: hw/rtl/sgacs_lane.sv
// Scaling lane: clamp, multiply, restoring divide one bit per cycle, offset
`timescale 1ns / 1ps
module sgacs_lane
  import sgacs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [ChW-1:0]        v_i,
  input  thresh_t               th_i,
  input  logic signed [12:0]    omin_i,
  input  logic signed [12:0]    omax_i,
  output logic                  done_o,
  output logic signed [12:0]    res_o
);
  localparam int unsigned QW = 25;

  logic [4:0]          cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic [QW-1:0]       num_q, num_d;
  logic [ChW:0]        rem_q, rem_d;
  logic [ChW-1:0]      den_q, den_d;
  logic                neg_q, neg_d;
  logic signed [12:0]  omin_q, omin_d;
  logic signed [12:0]  res_q, res_d;
  logic                done_q, done_d;

  logic [13:0]         diff;
  logic [13:0]         mag;
  logic [ChW:0]        trial;
  logic [ChW+1:0]      sub;
  logic [QW-1:0]       quo;
  logic signed [13:0]  sq;

  always_comb begin
    diff  = 14'($signed(omax_i) - $signed(omin_i));
    mag   = diff[13] ? 14'(-diff) : diff;
    trial = {rem_q[ChW-1:0], num_q[QW-1]};
    sub   = {1'b0, trial} - {2'b0, den_q};
    quo   = sub[ChW+1] ? {num_q[QW-2:0], 1'b0} : {num_q[QW-2:0], 1'b1};
    sq    = neg_q ? 14'(-$signed({1'b0, 13'(quo)})) : $signed({1'b0, 13'(quo)});
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    omin_d = omin_q;
    res_d  = res_q;
    done_d = 1'b0;
    if (start_i) begin
      if (v_i <= th_i.lo) begin
        res_d  = omin_i;
        done_d = 1'b1;
      end else if (v_i >= th_i.hi) begin
        res_d  = omax_i;
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
        cnt_d  = 5'(QW);
        num_d  = QW'((v_i - th_i.lo) * mag[12:0]);
        rem_d  = '0;
        den_d  = th_i.hi - th_i.lo;
        neg_d  = diff[13];
        omin_d = omin_i;
      end
    end else if (busy_q) begin
      rem_d = sub[ChW+1] ? trial : sub[ChW:0];
      num_d = quo;
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = 13'(sq + 14'(omin_q));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    omin_q <= omin_d;
    res_q  <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;
endmodule

FILE: hw/rtl/sgacs_gesture.sv
// Gesture classifier and hold counter with arming state
`timescale 1ns / 1ps
module sgacs_gesture
  import sgacs_pkg::*;
#(
  parameter bit LOG_GESTURES = 1'b1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           frame_i,
  input  logic           failsafe_i,
  input  logic [ChW-1:0] thr_i,
  input  logic [ChW-1:0] ele_i,
  input  logic [ChW-1:0] rud_i,
  input  thresh_t        th_i,
  input  logic [15:0]    hold_frames_i,
  output flags_t         flags_o
);
  logic     armed_q, armed_d;
  gesture_e last_q, last_d;
  logic [15:0] hold_q, hold_d;
  flags_t   flags_q, flags_d;
  gesture_e g;
  logic tl, th, rl, rh, eh;
  logic [15:0] hinc;

  always_comb begin
    tl = thr_i <= th_i.lo;
    th = thr_i >= th_i.hi;
    rl = rud_i <= th_i.lo;
    rh = rud_i >= th_i.hi;
    eh = ele_i >= th_i.hi;
    if (armed_q && tl && rl && !eh)                      g = G_DISARM;
    else if (!armed_q && tl && rh && !eh)                g = G_ARM;
    else if (!armed_q && tl && rl && eh)                 g = G_CALIBRATE;
    else if (LOG_GESTURES && !armed_q && th && rh && !eh) g = G_RECORD;
    else if (LOG_GESTURES && !armed_q && th && rl && !eh) g = G_READ;
    else                                                 g = G_UNKNOWN;
  end

  always_comb begin
    armed_d = armed_q;
    last_d  = last_q;
    hold_d  = hold_q;
    flags_d = flags_q;
    hinc    = (g == G_UNKNOWN) ? 16'd0 : hold_q;
    if (failsafe_i) begin
      armed_d = 1'b0;
      flags_d = '0;
    end else if (frame_i) begin
      flags_d = '0;
      if (g == last_q) begin
        if (hinc != 16'hFFFF) hinc = hinc + 16'd1;
        hold_d = hinc;
        if (hinc >= hold_frames_i && g != G_UNKNOWN) begin
          hold_d = '0;
          case (g)
            G_ARM: begin
              armed_d           = 1'b1;
              flags_d.arm_pulse = 1'b1;
            end
            G_DISARM:    armed_d = 1'b0;
            G_CALIBRATE: flags_d.calibrate_pulse = 1'b1;
            G_RECORD:    flags_d.record_pulse = 1'b1;
            default:     flags_d.read_pulse = 1'b1;
          endcase
        end
      end else begin
        last_d = g;
        hold_d = '0;
      end
    end
    flags_d.is_armed = armed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      last_q  <= G_UNKNOWN;
      hold_q  <= '0;
      flags_q <= '0;
    end else begin
      armed_q <= armed_d;
      last_q  <= last_d;
      hold_q  <= hold_d;
      flags_q <= flags_d;
    end
  end

  assign flags_o = flags_q;
endmodule

FILE: hw/rtl/sgacs_merge.sv
// Merge stage: gathers lane results into the held target registers
`timescale 1ns / 1ps
module sgacs_merge
  import sgacs_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    clr_i,
  input  logic                    failsafe_i,
  input  logic [ChW-1:0]          floor_i,
  input  logic [NumLanes-1:0]     done_i,
  input  logic [NumLanes*13-1:0]  res_i,
  output logic                    all_o,
  output logic [NumLanes*ChW-1:0] tgt_o
);
  logic [NumLanes-1:0]     seen_q, seen_d;
  logic [NumLanes*ChW-1:0] tgt_q, tgt_d;

  always_comb begin
    seen_d = clr_i ? '0 : (seen_q | done_i);
    tgt_d  = tgt_q;
    for (int i = 0; i < NumLanes; i++) begin
      if (done_i[i]) tgt_d[i*ChW +: ChW] = res_i[i*13 +: ChW];
    end
    if (failsafe_i) tgt_d[0 +: ChW] = floor_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      tgt_q  <= '0;
    end else begin
      seen_q <= seen_d;
      tgt_q  <= tgt_d;
    end
  end

  assign all_o = &seen_q;
  assign tgt_o = tgt_q;
endmodule

FILE: hw/rtl/stick_gesture_arming_and_channel_scaler_top.sv
// Top level: stick gesture arming and six-lane channel scaler
// A frame request is registered and starts all six lanes; each lane clamps or runs its
// 25-step divider, and the result turns valid once the merge stage has seen every lane
// done. A failsafe request turns the result valid without waiting for the lanes.
// Throughput: one request at a time; ready returns the cycle after the result is taken.
// Reset (rst_ni low, async): disarmed, counters and targets zero, registers at defaults.
`timescale 1ns / 1ps
module stick_gesture_arming_and_channel_scaler_top
  import sgacs_pkg::*;
#(
  parameter int unsigned AUX_SPAN     = 500,
  parameter bit          LOG_GESTURES = 1'b1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  sgacs_in_if.sink         in_if,
  sgacs_out_if.source      out_if,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [11:0] lo_q, hi_q, floor_q, ceil_q;
  logic [15:0] hold_q;
  logic [10:0] ail_q, ele_q, rud_q;
  state_e      st_q, st_d;
  logic        wr;
  reg_idx_e    ridx;
  logic [15:0] fc_q, fc_d;
  logic        start_q, fs_q;
  logic [NumLanes*ChW-1:0] ch_q;
  logic [NumLanes-1:0]     ldone;
  logic [NumLanes*13-1:0]  lres;
  logic [NumLanes*26-1:0]  rng;
  logic        all_done;
  logic [NumLanes*ChW-1:0] tgt;
  flags_t      flags;
  thresh_t     th;
  logic        acc, fin;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = reg_idx_e'(paddr[4:2]);
  assign th     = '{lo: lo_q, hi: hi_q};

  always_comb begin
    unique case (ridx)
      REG_STICK_LOW:   prdata = 32'(lo_q);
      REG_STICK_HIGH:  prdata = 32'(hi_q);
      REG_HOLD_FRAMES: prdata = 32'(hold_q);
      REG_THR_FLOOR:   prdata = 32'(floor_q);
      REG_THR_CEILING: prdata = 32'(ceil_q);
      REG_AIL_SPAN:    prdata = 32'(ail_q);
      REG_ELE_SPAN:    prdata = 32'(ele_q);
      REG_RUD_SPAN:    prdata = 32'(rud_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= 12'd1000; hi_q <= 12'd2000; hold_q <= 16'd50; floor_q <= '0;
      ceil_q <= 12'd1000; ail_q <= 11'd200; ele_q <= 11'd200; rud_q <= 11'd200;
    end else if (wr && paddr[1:0] == 2'b00) begin
      unique case (ridx)
        REG_STICK_LOW:   lo_q    <= pwdata[11:0];
        REG_STICK_HIGH:  hi_q    <= pwdata[11:0];
        REG_HOLD_FRAMES: hold_q  <= pwdata[15:0];
        REG_THR_FLOOR:   floor_q <= pwdata[11:0];
        REG_THR_CEILING: ceil_q  <= pwdata[11:0];
        REG_AIL_SPAN:    ail_q   <= pwdata[10:0];
        REG_ELE_SPAN:    ele_q   <= pwdata[10:0];
        REG_RUD_SPAN:    rud_q   <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  assign acc = in_if.valid && in_if.ready;
  assign fin = out_if.valid && out_if.ready;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (acc) st_d = ST_RUN;
      ST_RUN:  if (fs_q || (all_done && !start_q)) st_d = ST_OUT;
      ST_OUT:  if (fin) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_if.ready  = (st_q == ST_IDLE);
    out_if.valid = (st_q == ST_OUT);
    fc_d         = (acc && in_if.command == CMD_FRAME) ? fc_q + 16'd1 : fc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      fc_q    <= '0;
      start_q <= 1'b0;
      fs_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      fc_q    <= fc_d;
      start_q <= acc && in_if.command == CMD_FRAME;
      fs_q    <= acc && in_if.command == CMD_FAILSAFE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) ch_q <= {in_if.aux_two_in, in_if.aux_one_in, in_if.rudder_in,
                      in_if.elevator_in, in_if.aileron_in, in_if.throttle_in};
  end

  always_comb begin
    rng[0 +: 26]  = {13'(floor_q), 13'(ceil_q)};
    rng[26 +: 26] = {13'(-$signed({2'b0, ail_q})), 13'({2'b0, ail_q})};
    rng[52 +: 26] = {13'(-$signed({2'b0, ele_q})), 13'({2'b0, ele_q})};
    rng[78 +: 26] = {13'(-$signed({2'b0, rud_q})), 13'({2'b0, rud_q})};
    rng[104 +: 26] = {13'(-$signed(13'(AUX_SPAN))), 13'(AUX_SPAN)};
    rng[130 +: 26] = {13'(-$signed(13'(AUX_SPAN))), 13'(AUX_SPAN)};
  end

  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    sgacs_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .start_i(start_q),
      .v_i    (ch_q[i*ChW +: ChW]),
      .th_i   (th),
      .omin_i (rng[i*26+13 +: 13]),
      .omax_i (rng[i*26 +: 13]),
      .done_o (ldone[i]),
      .res_o  (lres[i*13 +: 13])
    );
  end

  sgacs_gesture #(.LOG_GESTURES(LOG_GESTURES)) u_gesture (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_i      (start_q),
    .failsafe_i   (fs_q),
    .thr_i        (ch_q[0 +: ChW]),
    .ele_i        (ch_q[2*ChW +: ChW]),
    .rud_i        (ch_q[3*ChW +: ChW]),
    .th_i         (th),
    .hold_frames_i(hold_q),
    .flags_o      (flags)
  );

  sgacs_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (start_q),
    .failsafe_i(fs_q),
    .floor_i   (floor_q),
    .done_i    (ldone),
    .res_i     (lres),
    .all_o     (all_done),
    .tgt_o     (tgt)
  );

  assign out_if.throttle_target = tgt[0 +: ChW];
  assign out_if.aileron_target  = $signed(tgt[ChW +: ChW]);
  assign out_if.elevator_target = $signed(tgt[2*ChW +: ChW]);
  assign out_if.rudder_target   = $signed(tgt[3*ChW +: ChW]);
  assign out_if.aux_one_target  = $signed(tgt[4*ChW +: ChW]);
  assign out_if.aux_two_target  = $signed(tgt[5*ChW +: ChW]);
  assign out_if.is_armed        = flags.is_armed;
  assign out_if.arm_pulse       = flags.arm_pulse;
  assign out_if.calibrate_pulse = flags.calibrate_pulse;
  assign out_if.record_pulse    = flags.record_pulse;
  assign out_if.read_pulse      = flags.read_pulse;
  assign out_if.frame_count     = fc_q;

  a_one_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> $onehot0({flags.arm_pulse, flags.calibrate_pulse,
                               flags.record_pulse, flags.read_pulse}))
    else $error("more than one gesture pulse");
  a_arm_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && flags.arm_pulse |-> flags.is_armed)
    else $error("arm pulse without armed");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> !out_if.valid)
    else $error("request taken while result pending");
endmodule
